// ===== design/exlex_pkg.sv =====
package exlex_pkg;

  // Scan mode, one-hot
  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_INT   = 5'b00010,
    M_REAL  = 5'b00100,
    M_IDENT = 5'b01000,
    M_ERR   = 5'b10000
  } scan_mode_t;

  // Token kinds as carried in the result item
  typedef enum logic [4:0] {
    K_REAL    = 5'd0,
    K_INT     = 5'd1,
    K_LPAREN  = 5'd2,
    K_RPAREN  = 5'd3,
    K_PLUS    = 5'd4,
    K_MINUS   = 5'd5,
    K_STAR    = 5'd6,
    K_SLASH   = 5'd7,
    K_COMMA   = 5'd8,
    K_EQUAL   = 5'd9,
    K_LET     = 5'd10,
    K_IN      = 5'd11,
    K_STATIC  = 5'd12,
    K_DYNAMIC = 5'd13,
    K_IDENT   = 5'd14,
    K_ERROR   = 5'd15,
    K_END     = 5'd16
  } token_kind_t;

  localparam int NUM_KW    = 4;
  localparam int MAX_RES   = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW   = 3;
  localparam int CNT_W     = 4;

  // Keyword candidate state after one more identifier character
  typedef struct packed {
    logic [NUM_KW-1:0] alive;
    logic [2:0]        len;
  } kw_state_t;

  // Pending-token flush outcome
  typedef struct packed {
    logic        valid;
    token_kind_t kind;
  } flush_t;

  function automatic logic dec_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  // Single-character tokens: hit flag plus kind
  function automatic flush_t single_token(input logic [7:0] c);
    flush_t r;
    r.valid = 1'b1;
    case (c)
      8'h28:   r.kind = K_LPAREN;
      8'h29:   r.kind = K_RPAREN;
      8'h2b:   r.kind = K_PLUS;
      8'h2d:   r.kind = K_MINUS;
      8'h2a:   r.kind = K_STAR;
      8'h2f:   r.kind = K_SLASH;
      8'h2c:   r.kind = K_COMMA;
      8'h3d:   r.kind = K_EQUAL;
      default: begin
        r.valid = 1'b0;
        r.kind  = K_ERROR;
      end
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd0:    r = 3'd3;
      2'd1:    r = 3'd2;
      2'd2:    r = 3'd6;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // Character idx of keyword k: let, in, static, dynamic
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0:    r = 8'h6c;
          3'd1:    r = 8'h65;
          3'd2:    r = 8'h74;
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0:    r = 8'h69;
          3'd1:    r = 8'h6e;
          default: r = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    r = 8'h73;
          3'd1:    r = 8'h74;
          3'd2:    r = 8'h61;
          3'd3:    r = 8'h74;
          3'd4:    r = 8'h69;
          3'd5:    r = 8'h63;
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    r = 8'h64;
          3'd1:    r = 8'h79;
          3'd2:    r = 8'h6e;
          3'd3:    r = 8'h61;
          3'd4:    r = 8'h6d;
          3'd5:    r = 8'h69;
          default: r = 8'h63;
        endcase
      end
    endcase
    return r;
  endfunction

  // Drop keyword candidates that no longer match, count length (saturating)
  function automatic kw_state_t kw_feed(input kw_state_t s, input logic [7:0] c);
    kw_state_t r;
    r = s;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!((s.len < kw_len(2'(k))) && (kw_char(2'(k), s.len) == c)))
        r.alive[k] = 1'b0;
    end
    if (s.len != 3'd7)
      r.len = s.len + 3'd1;
    return r;
  endfunction

  // Kind of the pending token, if any
  function automatic flush_t flush_kind(input scan_mode_t m, input kw_state_t s);
    flush_t r;
    r.valid = 1'b0;
    r.kind  = K_IDENT;
    case (m)
      M_INT: begin
        r.valid = 1'b1;
        r.kind  = K_INT;
      end
      M_REAL: begin
        r.valid = 1'b1;
        r.kind  = K_REAL;
      end
      M_IDENT: begin
        r.valid = 1'b1;
        // first matching keyword wins: scan downward, lowest overwrites
        for (int k = NUM_KW - 1; k >= 0; k--) begin
          if (s.alive[k] && (kw_len(2'(k)) == s.len))
            r.kind = token_kind_t'(5'(int'(K_LET) + k));
        end
      end
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/expression_lexer.sv =====
// Expression lexer: one source byte per input item, tokens out.
// Input channel: in_tdata carries the character, in_tlast marks the final
// character of a text. Result channel: out_tdata carries token kind, start
// offset and end offset; out_tlast marks the last token caused by an input.
// A text ends with an end-marker token, after which the next byte starts a
// new text at offset 0.
// An item's first token is offered once the item has passed the input
// register and been written into the token queue.
// Throughput: one character per cycle; each character yields zero to three
// tokens, leaving an 8-entry queue at one token per cycle while out_tready
// is high. The input stalls when the queue cannot take three more tokens.
// Reset: synchronous, active low; clears the scan state, the position and
// the queue, so no token is offered until the first character arrives.
// A stalled receiver holds the head token stable; the queue keeps filling
// until it has fewer than three free entries, then in_tready drops.
module expression_lexer
  import exlex_pkg::*;
#(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] token_kind, [20:5] start_pos, [36:21] end_pos
  output logic        out_tlast   // run_last
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef struct packed {
    token_kind_t         kind;
    logic [POS_BITS-1:0] spos;
    logic [POS_BITS-1:0] epos;
    logic                rlast;
  } entry_t;

  // Input register
  logic                inv_r;
  logic [7:0]          char_r;
  logic                last_r;

  // Scan state
  scan_mode_t          mode_r, mode_nxt;
  logic [POS_BITS-1:0] tstart_r, tstart_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  kw_state_t           kw_r, kw_nxt;

  // Token queue
  entry_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wptr_r, rptr_r;
  logic [CNT_W-1:0]    cnt_r;

  entry_t              res_c [MAX_RES];
  logic [1:0]          n_c;
  logic                go;
  logic                pop;
  logic                used;
  logic [POS_BITS-1:0] pn;
  flush_t              fk;
  flush_t              sk;
  entry_t              head;

  assign go        = inv_r && (cnt_r <= CNT_W'(FIFO_DEPTH - MAX_RES));
  assign in_tready = !inv_r || go;
  assign pop       = out_tvalid && out_tready;

  // Load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_tready) begin
      inv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // Scan one character: next state and up to three tokens
  always_comb begin
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    kw_nxt     = kw_r;
    n_c        = 2'd0;
    used       = 1'b0;
    fk         = '0;
    sk         = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res_c[i] = '0;
    end

    if (mode_r != M_ERR && pos_r == POS_MAX) begin
      // position overflow: flush, then error
      fk = flush_kind(mode_nxt, kw_nxt);
      if (fk.valid) begin
        res_c[n_c] = '{kind: fk.kind, spos: tstart_nxt, epos: pos_r, rlast: 1'b0};
        n_c = n_c + 2'd1;
      end
      res_c[n_c] = '{kind: K_ERROR, spos: pos_r, epos: pos_r, rlast: 1'b0};
      n_c = n_c + 2'd1;
      mode_nxt = M_ERR;
    end else if (mode_r != M_ERR) begin
      // try to extend the pending token
      case (mode_r)
        M_INT: begin
          if (dec_digit(char_r)) begin
            used = 1'b1;
          end else if (char_r == 8'h2e) begin
            mode_nxt = M_REAL;
            used     = 1'b1;
          end
        end
        M_REAL: begin
          if (dec_digit(char_r)) used = 1'b1;
        end
        M_IDENT: begin
          if (dec_digit(char_r) || alpha_char(char_r)) begin
            kw_nxt = kw_feed(kw_r, char_r);
            used   = 1'b1;
          end
        end
        default: used = 1'b0;
      endcase

      if (!used) begin
        fk = flush_kind(mode_r, kw_r);
        if (fk.valid) begin
          res_c[n_c] = '{kind: fk.kind, spos: tstart_r, epos: pos_r, rlast: 1'b0};
          n_c = n_c + 2'd1;
        end
        mode_nxt = M_IDLE;
        sk = single_token(char_r);
        if (is_space(char_r)) begin
          mode_nxt = M_IDLE;
        end else if (dec_digit(char_r)) begin
          mode_nxt   = M_INT;
          tstart_nxt = pos_r;
        end else if (alpha_char(char_r)) begin
          mode_nxt   = M_IDENT;
          tstart_nxt = pos_r;
          kw_nxt     = kw_feed('{alive: '1, len: 3'd0}, char_r);
        end else if (sk.valid) begin
          res_c[n_c] = '{kind: sk.kind, spos: pos_r, epos: pos_r + 1'b1, rlast: 1'b0};
          n_c = n_c + 2'd1;
        end else begin
          res_c[n_c] = '{kind: K_ERROR, spos: pos_r, epos: pos_r + 1'b1, rlast: 1'b0};
          n_c = n_c + 2'd1;
          mode_nxt = M_ERR;
        end
      end
    end

    // advance position, saturating
    pn      = (pos_r == POS_MAX) ? pos_r : pos_r + 1'b1;
    pos_nxt = pn;

    // end of text: flush, end marker, back to reset state
    if (last_r) begin
      fk = flush_kind(mode_nxt, kw_nxt);
      if (fk.valid) begin
        res_c[n_c] = '{kind: fk.kind, spos: tstart_nxt, epos: pn, rlast: 1'b0};
        n_c = n_c + 2'd1;
      end
      res_c[n_c] = '{kind: K_END, spos: pn, epos: pn, rlast: 1'b0};
      n_c = n_c + 2'd1;
      mode_nxt   = M_IDLE;
      tstart_nxt = '0;
      pos_nxt    = '0;
      kw_nxt     = '{alive: '1, len: 3'd0};
    end

    // mark the last token of this item
    if (n_c != 2'd0) begin
      res_c[n_c - 2'd1].rlast = 1'b1;
    end
  end

  // Commit scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      tstart_r <= '0;
      pos_r    <= '0;
      kw_r     <= '{alive: '1, len: 3'd0};
    end else if (go) begin
      mode_r   <= mode_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      kw_r     <= kw_nxt;
    end
  end

  // Push tokens into the queue
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < n_c)
          mem[wptr_r + FIFO_AW'(i)] <= res_c[i];
      end
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (go)
        wptr_r <= wptr_r + FIFO_AW'(n_c);
      if (pop)
        rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_r + (go ? CNT_W'(n_c) : '0) - CNT_W'(pop);
    end
  end

  // Present the head token
  assign head       = mem[rptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = head.rlast;

  generate
    if (POS_BITS >= 16) begin : g_pos_trunc
      assign out_tdata = {3'b000, head.epos[15:0], head.spos[15:0], head.kind};
    end else begin : g_pos_ext
      assign out_tdata = {3'b000, 16'(head.epos), 16'(head.spos), head.kind};
    end
  endgenerate

endmodule
